@@ hdl/lsst_pkg.sv @@
// shared constants and control/status types for the lru session slot table
package lsst_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int AGE_BITS_DEF   = 16;
	localparam int KEY_W          = 32;
	localparam int SLOT_OUT_W     = 3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic start;      // latch key, clear scan trackers and slot counter
		logic rd_en;      // read slot at counter, advance counter
		logic age_phase;  // reads belong to the age update sweep
		logic clr_idx;    // rewind slot counter
		logic fill;       // write key into the chosen slot
		logic out_load;   // load result register
	} lsst_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic last_idx;   // counter points at the last slot
		logic hit;        // key found in a valid slot
		logic out_free;   // result register can take a beat this cycle
	} lsst_status_t;

endpackage

@@ hdl/lru_session_slot_table_core.sv @@
// top level of the lru session slot table: controller plus slot datapath
//
// channel   direction  handshake                    payload
// lookup    in         lookup_valid / lookup_stall  lookup_key[31:0]
// result    out        result_valid / result_stall  slot_index[2:0], was_hit, did_evict,
//                                                   evicted_key[31:0]
//
// one lookup at a time; the slots are scanned one per cycle through a single
// key comparator reading the key and age memories
// miss: after the scan the key is written into the chosen slot, then the result is loaded
// hit: a second one-slot-per-cycle sweep updates the ages before the result is loaded
// reset clears the valid bits and the control state; no clearing pass is needed
// a result waits in its own register under result_stall; the next lookup is
// taken once the table is idle, and only the final load waits for a stalled result
module lru_session_slot_table_core #(
	parameter int SLOT_COUNT = lsst_pkg::SLOT_COUNT_DEF,
	parameter int AGE_BITS   = lsst_pkg::AGE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            lookup_valid,
	output logic                            lookup_stall,
	input  logic [lsst_pkg::KEY_W-1:0]      lookup_key,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [lsst_pkg::SLOT_OUT_W-1:0] slot_index,
	output logic                            was_hit,
	output logic                            did_evict,
	output logic [lsst_pkg::KEY_W-1:0]      evicted_key
);

	lsst_pkg::lsst_cmd_t    cmd;
	lsst_pkg::lsst_status_t status;

	// sequencer: scan, age sweep or fill, then result load
	lsst_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.lookup_valid (lookup_valid),
		.lookup_stall (lookup_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// key/age memories, valid bits, scan trackers and result register
	lsst_dpath #(
		.SLOT_COUNT (SLOT_COUNT),
		.AGE_BITS   (AGE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.lookup_key   (lookup_key),
		.cmd          (cmd),
		.status       (status),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.slot_index   (slot_index),
		.was_hit      (was_hit),
		.did_evict    (did_evict),
		.evicted_key  (evicted_key)
	);

	// a taken lookup keeps the table busy the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(lookup_valid && !lookup_stall) |=> lookup_stall)
		else $error("lookup taken while previous one still in progress");

	// a new result only comes out of a busy table
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(lookup_stall))
		else $error("result appeared without a lookup in progress");

	// fill and age sweep never overlap
	a_fill_not_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> !cmd.rd_en && !cmd.age_phase)
		else $error("fill issued during a slot sweep");

endmodule

@@ hdl/lsst_ctrl.sv @@
// controller state machine for the lru session slot table
module lsst_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  lookup_valid,
	output logic                  lookup_stall,
	input  lsst_pkg::lsst_status_t status,
	output lsst_pkg::lsst_cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_SCAN      = 7'b0000010,
		S_SCAN_END  = 7'b0000100,
		S_AGE       = 7'b0001000,
		S_AGE_END   = 7'b0010000,
		S_FILL      = 7'b0100000,
		S_DONE      = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		lookup_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				lookup_stall = 1'b0;
				if (lookup_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (status.last_idx) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				// last compare lands this cycle
				cmd.clr_idx = 1'b1;
				state_d     = status.hit ? S_AGE : S_FILL;
			end
			S_AGE: begin
				cmd.rd_en     = 1'b1;
				cmd.age_phase = 1'b1;
				if (status.last_idx) begin
					state_d = S_AGE_END;
				end
			end
			S_AGE_END: begin
				cmd.age_phase = 1'b1;
				state_d       = S_DONE;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/lsst_dpath.sv @@
// slot memories, scan trackers and result register for the lru session slot table
module lsst_dpath #(
	parameter int SLOT_COUNT = lsst_pkg::SLOT_COUNT_DEF,
	parameter int AGE_BITS   = lsst_pkg::AGE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [lsst_pkg::KEY_W-1:0]         lookup_key,
	input  lsst_pkg::lsst_cmd_t                cmd,
	output lsst_pkg::lsst_status_t             status,
	input  logic                               result_stall,
	output logic                               result_valid,
	output logic [lsst_pkg::SLOT_OUT_W-1:0]    slot_index,
	output logic                               was_hit,
	output logic                               did_evict,
	output logic [lsst_pkg::KEY_W-1:0]         evicted_key
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
	localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	logic [lsst_pkg::KEY_W-1:0] key_mem [SLOT_COUNT];
	logic [AGE_BITS-1:0]        age_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]      valid_q;

	logic [IDX_W-1:0]           rd_idx_q;
	logic                       rd_vld_s1;
	logic                       phase_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic                       vld_s1;
	logic [lsst_pkg::KEY_W-1:0] key_s1;
	logic [AGE_BITS-1:0]        age_s1;

	logic [lsst_pkg::KEY_W-1:0] key_q;
	logic                       hit_q;
	logic                       free_q;
	logic [IDX_W-1:0]           hit_idx_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic [IDX_W-1:0]           old_idx_q;
	logic [AGE_BITS-1:0]        oldest_q;
	logic [lsst_pkg::KEY_W-1:0] old_key_q;

	logic                       scan_s1;
	logic                       match_s1;
	logic [IDX_W-1:0]           tgt_idx;
	logic                       age_we;
	logic [IDX_W-1:0]           age_wa;
	logic [AGE_BITS-1:0]        age_wd;
	logic [31:0]                slot_ext;

	assign scan_s1  = rd_vld_s1 && !phase_s1;
	assign match_s1 = scan_s1 && vld_s1 && (key_s1 == key_q);
	assign tgt_idx  = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);
	assign slot_ext = 32'(tgt_idx);

	assign status.last_idx = (rd_idx_q == IDX_LAST);
	assign status.hit      = hit_q || match_s1;
	assign status.out_free = !result_valid || !result_stall;

	// slot counter and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.start || cmd.clr_idx) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			idx_s1   <= rd_idx_q;
			phase_s1 <= cmd.age_phase;
			vld_s1   <= valid_q[rd_idx_q];
		end
	end

	// key memory
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			key_s1 <= key_mem[rd_idx_q];
		end
		if (cmd.fill) begin
			key_mem[tgt_idx] <= key_q;
		end
	end

	// age write: sweep update after a hit, or zero on fill
	always_comb begin
		age_we = 1'b0;
		age_wa = idx_s1;
		age_wd = age_s1;
		if (cmd.fill) begin
			age_we = 1'b1;
			age_wa = tgt_idx;
			age_wd = '0;
		end else if (rd_vld_s1 && phase_s1) begin
			age_we = 1'b1;
			if (idx_s1 == hit_idx_q) begin
				age_wd = '0;
			end else if (vld_s1 && (age_s1 != AGE_MAX)) begin
				age_wd = age_s1 + 1'b1;
			end
		end
	end

	// age memory
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			age_s1 <= age_mem[rd_idx_q];
		end
		if (age_we) begin
			age_mem[age_wa] <= age_wd;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.fill) begin
			valid_q[tgt_idx] <= 1'b1;
		end
	end

	// scan trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (scan_s1) begin
			if (match_s1 && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!vld_s1) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q    <= lookup_key;
			oldest_q <= '0;
		end else if (scan_s1) begin
			// lowest matching slot wins
			if (match_s1 && !hit_q) begin
				hit_idx_q <= idx_s1;
			end
			// highest empty slot wins
			if (!vld_s1) begin
				free_idx_q <= idx_s1;
			end
			// greatest age, ties to the higher slot
			if (age_s1 >= oldest_q) begin
				oldest_q  <= age_s1;
				old_idx_q <= idx_s1;
				old_key_q <= key_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			slot_index  <= slot_ext[lsst_pkg::SLOT_OUT_W-1:0];
			was_hit     <= hit_q;
			did_evict   <= !hit_q && !free_q;
			evicted_key <= (!hit_q && !free_q) ? old_key_q : '0;
		end
	end

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the lru session slot table core
module tb;

	localparam int SLOTS      = lsst_pkg::SLOT_COUNT_DEF;
	localparam int AGE_W      = lsst_pkg::AGE_BITS_DEF;
	localparam int KEY_W      = lsst_pkg::KEY_W;
	localparam int SLOT_OUT_W = lsst_pkg::SLOT_OUT_W;
	// back-to-back hits on one resident key while the other slots keep aging
	localparam int HAMMER_HITS    = 16;
	localparam int RANDOM_LOOKUPS = 1680;
	localparam int HOLD_CYCLES    = 400;

	typedef struct {
		logic [KEY_W-1:0] key;
		int               gap;  // idle cycles offered before this beat
	} lookup_item_t;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic                  hit;
		logic                  evict;
		logic [KEY_W-1:0]      old_key;
	} slot_result_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  lookup_valid = 1'b0;
	logic                  lookup_stall;
	logic [KEY_W-1:0]      lookup_key   = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic                  was_hit;
	logic                  did_evict;
	logic [KEY_W-1:0]      evicted_key;

	// predictor copy of the slot table
	logic             tbl_valid [SLOTS];
	logic [KEY_W-1:0] tbl_key   [SLOTS];
	logic [AGE_W-1:0] tbl_age   [SLOTS];

	lookup_item_t lookup_backlog  [$];
	slot_result_t pending_results [$];

	int lookups_taken = 0;
	int results_seen  = 0;
	int error_count   = 0;
	int idle_left     = 0;
	int stall_left    = 0;
	bit hold_done     = 1'b0;
	// result indexes of the hammer run and of the long receiver hold
	int sat_first     = 0;
	int sat_end       = 0;
	int hold_at       = 0;

	lru_session_slot_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.lookup_valid (lookup_valid),
		.lookup_stall (lookup_stall),
		.lookup_key   (lookup_key),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.slot_index   (slot_index),
		.was_hit      (was_hit),
		.did_evict    (did_evict),
		.evicted_key  (evicted_key)
	);

	always #5 clk = ~clk;

	// mostly short pauses, now and then a long one
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one lookup against the predictor table: returns the result and updates the table
	function automatic slot_result_t table_lookup(input logic [KEY_W-1:0] key);
		int           hit_at;
		int           free_at;
		int           tgt;
		logic [AGE_W-1:0] oldest;
		slot_result_t r;
		hit_at  = -1;
		free_at = -1;
		tgt     = 0;
		oldest  = '0;
		r       = '0;
		// scan stops at the first valid match; empties seen before it still count
		for (int s = 0; s < SLOTS; s++) begin
			if (hit_at < 0) begin
				if (!tbl_valid[s])
					free_at = s;
				else if (tbl_key[s] == key)
					hit_at = s;
			end
		end
		if (hit_at >= 0) begin
			// every valid slot ages, saturating, then the hit slot restarts
			for (int s = 0; s < SLOTS; s++) begin
				if (tbl_valid[s] && tbl_age[s] != '1)
					tbl_age[s] = tbl_age[s] + 1'b1;
			end
			tbl_age[hit_at] = '0;
			tgt   = hit_at;
			r.hit = 1'b1;
		end else begin
			if (free_at >= 0) begin
				tgt = free_at;
			end else begin
				// oldest slot goes, ties resolved toward the highest index
				for (int s = 0; s < SLOTS; s++) begin
					if (tbl_age[s] >= oldest) begin
						oldest = tbl_age[s];
						tgt    = s;
					end
				end
				r.evict   = 1'b1;
				r.old_key = tbl_key[tgt];
			end
			tbl_valid[tgt] = 1'b1;
			tbl_key[tgt]   = key;
			tbl_age[tgt]   = '0;
		end
		r.slot = tgt[SLOT_OUT_W-1:0];
		return r;
	endfunction

	task automatic queue_lookup(input logic [KEY_W-1:0] key, input int gap);
		lookup_item_t it;
		it.key = key;
		it.gap = gap;
		lookup_backlog.push_back(it);
	endtask

	// lookup driver: predicts on every accepted beat, holds the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		lookup_item_t nxt;
		if (!arst_n) begin
			lookup_valid <= 1'b0;
			lookup_key   <= '0;
			idle_left    <= 0;
		end else begin
			if (lookup_valid && !lookup_stall) begin
				pending_results.push_back(table_lookup(lookup_key));
				lookups_taken <= lookups_taken + 1;
			end
			// a stalled beat stays put; otherwise idle out the gap or offer the next key
			if (!(lookup_valid && lookup_stall)) begin
				if (idle_left > 0) begin
					lookup_valid <= 1'b0;
					idle_left    <= idle_left - 1;
				end else if (lookup_backlog.size() > 0) begin
					nxt = lookup_backlog.pop_front();
					lookup_valid <= 1'b1;
					lookup_key   <= nxt.key;
					idle_left    <= (lookup_backlog.size() > 0) ? lookup_backlog[0].gap : 0;
				end else begin
					lookup_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each accepted beat against the oldest prediction
	// and drives result_stall for the next cycle
	always @(posedge clk or negedge arst_n) begin
		slot_result_t want;
		logic         stall_next;
		bit           calm;
		int           pause;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with nothing pending: slot %0d hit %0b evict %0b key %h",
						$time, slot_index, was_hit, did_evict, evicted_key);
					error_count = error_count + 1;
				end else begin
					want = pending_results.pop_front();
					if (slot_index !== want.slot) begin
						$display("%0t: slot_index expected %0d actual %0d",
							$time, want.slot, slot_index);
						error_count = error_count + 1;
					end
					if (was_hit !== want.hit) begin
						$display("%0t: was_hit expected %0b actual %0b", $time, want.hit, was_hit);
						error_count = error_count + 1;
					end
					if (did_evict !== want.evict) begin
						$display("%0t: did_evict expected %0b actual %0b",
							$time, want.evict, did_evict);
						error_count = error_count + 1;
					end
					if (evicted_key !== want.old_key) begin
						$display("%0t: evicted_key expected %h actual %h",
							$time, want.old_key, evicted_key);
						error_count = error_count + 1;
					end
				end
				results_seen = results_seen + 1;
			end
			// no new stalls start during the hammer run and in regular quiet stretches
			calm = (results_seen >= sat_first && results_seen < sat_end) ||
				(results_seen % 250) < 50;
			// one long hold-off so the core fills up and pushes back on lookups
			if (!hold_done && hold_at > 0 && results_seen >= hold_at) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_next = 1'b1;
				stall_left = stall_left - 1;
			end else if (calm) begin
				stall_next = 1'b0;
			end else begin
				pause = pick_pause();
				stall_next = (pause > 0);
				if (pause > 0)
					stall_left = pause - 1;
			end
			result_stall <= stall_next;
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		logic [KEY_W-1:0] pool [16];
		logic [KEY_W-1:0] last_key;
		logic [KEY_W-1:0] key;
		int               span;
		int               r;
		int               total;

		for (int s = 0; s < SLOTS; s++) begin
			tbl_valid[s] = 1'b0;
			tbl_key[s]   = '0;
			tbl_age[s]   = '0;
		end

		// fill the empty table top down, ages all stay zero
		queue_lookup(32'h0000_0000, pick_pause());
		queue_lookup(32'hFFFF_FFFF, pick_pause());
		queue_lookup(32'hAAAA_AAAA, pick_pause());
		queue_lookup(32'h5555_5555, pick_pause());
		queue_lookup(32'h8000_0000, pick_pause());
		queue_lookup(32'h0000_0001, pick_pause());
		queue_lookup(32'h1234_5678, pick_pause());
		queue_lookup(32'hFEDC_BA98, pick_pause());
		// full table, every age zero: the top slot goes, twice in a row
		queue_lookup(32'h7FFF_FFFF, pick_pause());
		queue_lookup(32'h0000_0000, pick_pause());
		// hit, then a key one bit away from it
		queue_lookup(32'hFFFF_FFFF, pick_pause());
		queue_lookup(32'hFFFF_FFFE, pick_pause());
		queue_lookup(32'hAAAA_AAAA, pick_pause());
		queue_lookup(32'hAAAA_AAAA, pick_pause());
		queue_lookup(32'h5555_5555, pick_pause());
		queue_lookup(32'h8000_0000, pick_pause());
		queue_lookup(32'h0000_0001, pick_pause());
		queue_lookup(32'h0000_0002, pick_pause());
		queue_lookup(32'hFEDC_BA98, pick_pause());
		queue_lookup(32'h1234_5678, pick_pause());

		// hammer one resident key so the other ages climb together,
		// then a new key must evict the oldest of them
		sat_first = lookup_backlog.size();
		for (int n = 0; n < HAMMER_HITS; n++)
			queue_lookup(32'h1234_5678, 0);
		queue_lookup(32'hC0FF_EE00, 0);
		sat_end = lookup_backlog.size();
		hold_at = sat_end + 400;

		// random part: keys drawn mostly from a small, drifting working set
		for (int i = 0; i < 16; i++)
			pool[i] = $urandom;
		pool[0]  = '0;
		pool[1]  = '1;
		span     = 12;
		last_key = 32'hC0FF_EE00;
		for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
			if (n % 100 == 0)
				span = $urandom_range(4, 16);
			if ($urandom_range(0, 99) < 5)
				pool[$urandom_range(0, 15)] = $urandom;
			r = $urandom_range(0, 99);
			if (r < 70)
				key = pool[$urandom_range(0, span - 1)];
			else if (r < 80)
				key = last_key;
			else
				key = $urandom;
			last_key = key;
			queue_lookup(key, ((n % 250) < 50) ? 0 : pick_pause());
		end
		total = lookup_backlog.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (lookups_taken == total);
		wait (results_seen == lookups_taken);
		// let any stray beat show up before the verdict
		repeat (4 * SLOTS + 16) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("lru_session_slot_table_core: match");
		else
			$display("lru_session_slot_table_core: mismatch");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#10_000_000;
		$display("lru_session_slot_table_core: mismatch");
		$finish;
	end

endmodule
